// File: rtl/vertex_transform_project_macros.svh
// Assertion macros used by the checker file of the vertex transform block.
`ifndef VERTEX_TRANSFORM_PROJECT_MACROS_SVH
`define VERTEX_TRANSFORM_PROJECT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex transform check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertex transform check failed");

`endif

// File: rtl/vtp_pkg.sv
// Shared types, constants and a helper function of the vertex transform block.
package vtp_pkg;

    // Field and arithmetic widths.
    localparam int COORD_W          = 32;
    localparam int COEF_W           = 16;
    localparam int ROW_W            = 48;
    localparam int PROD_W           = 48;
    localparam int NEAR_W           = 52;
    localparam int MSUM_W           = 50;
    localparam int FRAC_SHIFT       = 14;
    localparam int QUOT_W           = 32;
    localparam int REM_W            = 31;
    localparam int DIV_BITS_DEFAULT = 4;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 48;

    // Numeric constants.
    localparam logic signed [20:0]       NEAR_SCALE = 21'sd1000000;
    localparam logic signed [MSUM_W-1:0] ROUND_HALF = 50'sd8192;
    localparam logic signed [31:0]       COORD_MAX  = 32'sh7FFFFFFF;
    localparam logic signed [31:0]       COORD_MIN  = 32'sh80000000;
    localparam logic [QUOT_W-1:0]        NEG_LIMIT  = 32'h80000000;

    // Register reset values: identity matrix, zero translation.
    localparam logic [ROW_W-1:0] ROW0_RESET = 48'h000000004000;
    localparam logic [ROW_W-1:0] ROW1_RESET = 48'h000040000000;
    localparam logic [ROW_W-1:0] ROW2_RESET = 48'h400000000000;

    typedef enum logic [1:0] {
        OP_XFORM = 2'd0,
        OP_TRANS = 2'd1,
        OP_PROJ  = 2'd2,
        OP_PASS  = 2'd3
    } vtp_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0    = 3'd0,
        REG_ROW1    = 3'd1,
        REG_ROW2    = 3'd2,
        REG_TRANS_X = 3'd3,
        REG_TRANS_Y = 3'd4,
        REG_TRANS_Z = 3'd5
    } vtp_reg_t;

    typedef struct packed {
        logic [2:0][ROW_W-1:0]   row;
        logic [2:0][COORD_W-1:0] trans;
    } vtp_cfg_t;

    // One lane of the restoring divider: partial remainder and the shift word
    // that feeds dividend bits in and collects quotient bits.
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [QUOT_W-1:0] work;
        logic              ovf;
        logic              neg;
    } vtp_lane_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] value;
        logic                      sat;
    } vtp_clamp_t;

    // First stage word: products, sums and divider setup.
    typedef struct packed {
        logic [2:0][2:0][PROD_W-1:0] prod;
        logic [NEAR_W-1:0]           near_x;
        logic [NEAR_W-1:0]           near_y;
        logic [COORD_W-1:0]          tx;
        logic [COORD_W-1:0]          ty;
        logic [COORD_W-1:0]          tz;
        logic                        tsat;
        vtp_op_t                     op;
        logic [COORD_W-1:0]          x;
        logic [COORD_W-1:0]          y;
        logic [COORD_W-1:0]          z;
        logic                        last;
        logic                        use_div;
        logic [REM_W-1:0]            divisor;
        vtp_lane_t                   lane_x;
        vtp_lane_t                   lane_y;
    } vtp_s1_t;

    // Word carried through the divider stages with the finished early result.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               sat;
        logic               last;
        logic               use_div;
        logic [REM_W-1:0]   divisor;
        vtp_lane_t          lane_x;
        vtp_lane_t          lane_y;
    } vtp_div_word_t;

    // Saturate a wide signed value to 32 bits and report clamping.
    function automatic vtp_clamp_t clamp32(input logic signed [63:0] v);
        vtp_clamp_t r;
        if (v > 64'(COORD_MAX)) begin
            r.value = COORD_MAX;
            r.sat   = 1'b1;
        end else if (v < 64'(COORD_MIN)) begin
            r.value = COORD_MIN;
            r.sat   = 1'b1;
        end else begin
            r.value = v[COORD_W-1:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: rtl/vtp_front.sv
// First pipeline stage: matrix and scale products, translation and divider setup.
module vtp_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          opcode,
    input  logic signed [vtp_pkg::COORD_W-1:0]  in_x,
    input  logic signed [vtp_pkg::COORD_W-1:0]  in_y,
    input  logic signed [vtp_pkg::COORD_W-1:0]  in_z,
    input  logic                                last_vertex,
    input  vtp_pkg::vtp_cfg_t                   cfg,
    output logic                                out_valid,
    input  logic                                out_ready,
    output vtp_pkg::vtp_s1_t                    out_word
);

    logic                         valid_reg;
    vtp_pkg::vtp_s1_t             word_reg;
    vtp_pkg::vtp_s1_t             word_next;
    logic signed [vtp_pkg::COORD_W-1:0] coord [3];
    vtp_pkg::vtp_clamp_t          tcx;
    vtp_pkg::vtp_clamp_t          tcy;
    vtp_pkg::vtp_clamp_t          tcz;

    // Divider lane setup: magnitude, first remainder and overflow test.
    // The quotient needs more than 32 bits exactly when |v| / 2^16 >= d.
    function automatic vtp_pkg::vtp_lane_t lane_init(
        input logic signed [vtp_pkg::COORD_W-1:0] v,
        input logic [vtp_pkg::REM_W-1:0]          d
    );
        logic [vtp_pkg::COORD_W-1:0] mag;
        vtp_pkg::vtp_lane_t          l;
        mag    = v[vtp_pkg::COORD_W-1] ? vtp_pkg::COORD_W'(-v) : vtp_pkg::COORD_W'(v);
        l.ovf  = {16'b0, mag[31:16]} >= {1'b0, d};
        l.rem  = {15'b0, mag[31:16]};
        l.work = {mag[15:0], 16'b0};
        l.neg  = v[vtp_pkg::COORD_W-1];
        return l;
    endfunction

    assign coord[0] = in_x;
    assign coord[1] = in_y;
    assign coord[2] = in_z;

    // Translation sums, saturated here since they are narrow.
    assign tcx = vtp_pkg::clamp32(64'(in_x) + 64'($signed(cfg.trans[0])));
    assign tcy = vtp_pkg::clamp32(64'(in_y) + 64'($signed(cfg.trans[1])));
    assign tcz = vtp_pkg::clamp32(64'(in_z) + 64'($signed(cfg.trans[2])));

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                word_next.prod[r][c] =
                    vtp_pkg::PROD_W'($signed(cfg.row[r][c*vtp_pkg::COEF_W +: vtp_pkg::COEF_W]))
                    * vtp_pkg::PROD_W'(coord[c]);
            end
        end
        word_next.near_x  = vtp_pkg::NEAR_W'(in_x) * vtp_pkg::NEAR_W'(vtp_pkg::NEAR_SCALE);
        word_next.near_y  = vtp_pkg::NEAR_W'(in_y) * vtp_pkg::NEAR_W'(vtp_pkg::NEAR_SCALE);
        word_next.tx      = tcx.value;
        word_next.ty      = tcy.value;
        word_next.tz      = tcz.value;
        word_next.tsat    = tcx.sat | tcy.sat | tcz.sat;
        word_next.op      = vtp_pkg::vtp_op_t'(opcode);
        word_next.x       = in_x;
        word_next.y       = in_y;
        word_next.z       = in_z;
        word_next.last    = last_vertex;
        word_next.use_div = (vtp_pkg::vtp_op_t'(opcode) == vtp_pkg::OP_PROJ) && (in_z > 0);
        word_next.divisor = in_z[vtp_pkg::REM_W-1:0];
        word_next.lane_x  = lane_init(in_x, in_z[vtp_pkg::REM_W-1:0]);
        word_next.lane_y  = lane_init(in_y, in_z[vtp_pkg::REM_W-1:0]);
    end

    // The stage takes a word when it is empty or its word moves on.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// File: rtl/vtp_merge.sv
// Second pipeline stage: matrix row sums with rounding, saturation and opcode select.
module vtp_merge (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  vtp_pkg::vtp_s1_t        in_word,
    output logic                    out_valid,
    input  logic                    out_ready,
    output vtp_pkg::vtp_div_word_t  out_word
);

    logic                              valid_reg;
    vtp_pkg::vtp_div_word_t            word_reg;
    vtp_pkg::vtp_div_word_t            word_next;
    logic signed [vtp_pkg::MSUM_W-1:0] msum [3];
    vtp_pkg::vtp_clamp_t               mres [3];
    vtp_pkg::vtp_clamp_t               nx;
    vtp_pkg::vtp_clamp_t               ny;

    // Row sums in Q20.30, rounded half up to Q16.16 by a floor shift.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            msum[r] = vtp_pkg::MSUM_W'($signed(in_word.prod[r][0]))
                    + vtp_pkg::MSUM_W'($signed(in_word.prod[r][1]))
                    + vtp_pkg::MSUM_W'($signed(in_word.prod[r][2]))
                    + vtp_pkg::ROUND_HALF;
            mres[r] = vtp_pkg::clamp32(
                64'($signed(msum[r][vtp_pkg::MSUM_W-1:vtp_pkg::FRAC_SHIFT])));
        end
    end

    // Near-plane scaling for a projection with z not positive.
    assign nx = vtp_pkg::clamp32(64'($signed(in_word.near_x)));
    assign ny = vtp_pkg::clamp32(64'($signed(in_word.near_y)));

    always_comb
    begin
        word_next.last    = in_word.last;
        word_next.use_div = in_word.use_div;
        word_next.divisor = in_word.divisor;
        word_next.lane_x  = in_word.lane_x;
        word_next.lane_y  = in_word.lane_y;
        unique case (in_word.op)
            vtp_pkg::OP_XFORM:
            begin
                word_next.x   = mres[0].value;
                word_next.y   = mres[1].value;
                word_next.z   = mres[2].value;
                word_next.sat = mres[0].sat | mres[1].sat | mres[2].sat;
            end
            vtp_pkg::OP_TRANS:
            begin
                word_next.x   = in_word.tx;
                word_next.y   = in_word.ty;
                word_next.z   = in_word.tz;
                word_next.sat = in_word.tsat;
            end
            vtp_pkg::OP_PROJ:
            begin
                // With a positive z the divider supplies x and y at the end.
                word_next.x   = in_word.use_div ? '0 : nx.value;
                word_next.y   = in_word.use_div ? '0 : ny.value;
                word_next.z   = '0;
                word_next.sat = !in_word.use_div && (nx.sat | ny.sat);
            end
            vtp_pkg::OP_PASS:
            begin
                word_next.x   = in_word.x;
                word_next.y   = in_word.y;
                word_next.z   = in_word.z;
                word_next.sat = 1'b0;
            end
            default:
            begin
                word_next.x   = in_word.x;
                word_next.y   = in_word.y;
                word_next.z   = in_word.z;
                word_next.sat = 1'b0;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// File: rtl/vtp_div_stage.sv
// One divider pipeline stage: DIV_BITS restoring steps on both quotient lanes.
module vtp_div_stage #(
    parameter int DIV_BITS = vtp_pkg::DIV_BITS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  vtp_pkg::vtp_div_word_t  in_word,
    output logic                    out_valid,
    input  logic                    out_ready,
    output vtp_pkg::vtp_div_word_t  out_word
);

    logic                   valid_reg;
    vtp_pkg::vtp_div_word_t word_reg;
    vtp_pkg::vtp_div_word_t word_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic vtp_pkg::vtp_lane_t div_step(
        input vtp_pkg::vtp_lane_t        l,
        input logic [vtp_pkg::REM_W-1:0] d
    );
        logic [vtp_pkg::QUOT_W-1:0] sh;
        logic [vtp_pkg::QUOT_W-1:0] diff;
        logic                       ge;
        vtp_pkg::vtp_lane_t         r;
        sh     = {l.rem, l.work[vtp_pkg::QUOT_W-1]};
        diff   = sh - {1'b0, d};
        ge     = sh >= {1'b0, d};
        r      = l;
        r.rem  = ge ? diff[vtp_pkg::REM_W-1:0] : sh[vtp_pkg::REM_W-1:0];
        r.work = {l.work[vtp_pkg::QUOT_W-2:0], ge};
        return r;
    endfunction

    always_comb
    begin
        word_next = in_word;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            word_next.lane_x = div_step(word_next.lane_x, in_word.divisor);
            word_next.lane_y = div_step(word_next.lane_y, in_word.divisor);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// File: rtl/vtp_out.sv
// Last pipeline stage: quotient sign and saturation, result select, output register.
module vtp_out (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  vtp_pkg::vtp_div_word_t              in_word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [vtp_pkg::COORD_W-1:0]  out_x,
    output logic signed [vtp_pkg::COORD_W-1:0]  out_y,
    output logic signed [vtp_pkg::COORD_W-1:0]  out_z,
    output logic                                saturated,
    output logic                                out_last
);

    logic                               valid_reg;
    logic signed [vtp_pkg::COORD_W-1:0] x_reg;
    logic signed [vtp_pkg::COORD_W-1:0] y_reg;
    logic signed [vtp_pkg::COORD_W-1:0] z_reg;
    logic                               sat_reg;
    logic                               last_reg;
    logic signed [vtp_pkg::COORD_W-1:0] x_next;
    logic signed [vtp_pkg::COORD_W-1:0] y_next;
    logic                               sat_next;
    vtp_pkg::vtp_clamp_t                qx;
    vtp_pkg::vtp_clamp_t                qy;

    // Apply the dividend sign to the quotient magnitude and saturate.
    function automatic vtp_pkg::vtp_clamp_t quot_finish(input vtp_pkg::vtp_lane_t l);
        vtp_pkg::vtp_clamp_t r;
        if (!l.neg)
        begin
            r.sat   = l.ovf | l.work[vtp_pkg::QUOT_W-1];
            r.value = r.sat ? vtp_pkg::COORD_MAX : $signed(l.work);
        end
        else
        begin
            r.sat   = l.ovf | (l.work > vtp_pkg::NEG_LIMIT);
            r.value = r.sat ? vtp_pkg::COORD_MIN : $signed(vtp_pkg::QUOT_W'(-l.work));
        end
        return r;
    endfunction

    assign qx = quot_finish(in_word.lane_x);
    assign qy = quot_finish(in_word.lane_y);

    always_comb
    begin
        if (in_word.use_div)
        begin
            x_next   = qx.value;
            y_next   = qy.value;
            sat_next = qx.sat | qy.sat;
        end
        else
        begin
            x_next   = in_word.x;
            y_next   = in_word.y;
            sat_next = in_word.sat;
        end
    end

    // Output register; it keeps its word while the receiver stalls.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= in_word.z;
            sat_reg  <= sat_next;
            last_reg <= in_word.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign saturated = sat_reg;
    assign out_last  = last_reg;

endmodule

// File: rtl/vertex_transform_project.sv
// Top level of the vertex transform and perspective divide pipeline.
//
// Input channel (in_valid / in_stall) carries one vertex word per transfer:
// opcode, in_x, in_y, in_z in signed Q16.16 and last_vertex. Output channel
// (out_valid / out_stall) returns one result word per vertex, in order:
// out_x, out_y, out_z, saturated and out_last.
// Opcode 0 applies the 3x3 Q2.14 matrix, opcode 1 adds the translation,
// opcode 2 divides x and y by z (scales by 1e6 when z is not positive),
// opcode 3 passes the vertex through.
// The stages are one product stage, one sum stage, the radix-2 restoring
// divider at DIV_BITS quotient bits per stage, and the output register.
// One word enters per cycle while in_stall is low.
// Every stage holds a valid bit; when out_stall is high the output register
// holds its word and empty stages upstream keep filling, so in_stall only
// rises once the pipeline between the ports is full.
// Configuration is written through cfg_valid / cfg_index / cfg_data; the user
// must do so only while no vertex is in flight, which the block does not
// enforce; cfg_ready is always high. Reset clears all valid bits and loads
// the identity matrix and a zero translation.
module vertex_transform_project #(
    parameter int DIV_BITS = vtp_pkg::DIV_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            opcode,
    input  logic signed [vtp_pkg::COORD_W-1:0]    in_x,
    input  logic signed [vtp_pkg::COORD_W-1:0]    in_y,
    input  logic signed [vtp_pkg::COORD_W-1:0]    in_z,
    input  logic                                  last_vertex,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [vtp_pkg::COORD_W-1:0]    out_x,
    output logic signed [vtp_pkg::COORD_W-1:0]    out_y,
    output logic signed [vtp_pkg::COORD_W-1:0]    out_z,
    output logic                                  saturated,
    output logic                                  out_last,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [vtp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [vtp_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int DIV_STAGES = vtp_pkg::QUOT_W / DIV_BITS;

    vtp_pkg::vtp_cfg_t      cfg_reg;
    logic                   front_ready;
    logic                   s1_valid;
    logic                   s1_ready;
    vtp_pkg::vtp_s1_t       s1_word;
    logic                   dv_valid [DIV_STAGES+1];
    logic                   dv_ready [DIV_STAGES+1];
    vtp_pkg::vtp_div_word_t dv_word  [DIV_STAGES+1];

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row[0]   <= vtp_pkg::ROW0_RESET;
            cfg_reg.row[1]   <= vtp_pkg::ROW1_RESET;
            cfg_reg.row[2]   <= vtp_pkg::ROW2_RESET;
            cfg_reg.trans[0] <= '0;
            cfg_reg.trans[1] <= '0;
            cfg_reg.trans[2] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (vtp_pkg::vtp_reg_t'(cfg_index))
                vtp_pkg::REG_ROW0:    cfg_reg.row[0]   <= cfg_data;
                vtp_pkg::REG_ROW1:    cfg_reg.row[1]   <= cfg_data;
                vtp_pkg::REG_ROW2:    cfg_reg.row[2]   <= cfg_data;
                vtp_pkg::REG_TRANS_X: cfg_reg.trans[0] <= cfg_data[vtp_pkg::COORD_W-1:0];
                vtp_pkg::REG_TRANS_Y: cfg_reg.trans[1] <= cfg_data[vtp_pkg::COORD_W-1:0];
                vtp_pkg::REG_TRANS_Z: cfg_reg.trans[2] <= cfg_data[vtp_pkg::COORD_W-1:0];
                default:              cfg_reg          <= cfg_reg;
            endcase
        end
    end

    assign in_stall = !front_ready;

    // Product and setup stage.
    vtp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (front_ready),
        .opcode      (opcode),
        .in_x        (in_x),
        .in_y        (in_y),
        .in_z        (in_z),
        .last_vertex (last_vertex),
        .cfg         (cfg_reg),
        .out_valid   (s1_valid),
        .out_ready   (s1_ready),
        .out_word    (s1_word)
    );

    // Sum, round and select stage.
    vtp_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_word   (s1_word),
        .out_valid (dv_valid[0]),
        .out_ready (dv_ready[0]),
        .out_word  (dv_word[0])
    );

    // Divider stages, DIV_BITS quotient bits each.
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        vtp_div_stage #(
            .DIV_BITS (DIV_BITS)
        ) u_div_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[k]),
            .in_ready  (dv_ready[k]),
            .in_word   (dv_word[k]),
            .out_valid (dv_valid[k+1]),
            .out_ready (dv_ready[k+1]),
            .out_word  (dv_word[k+1])
        );
    end

    // Final stage and output register.
    vtp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid[DIV_STAGES]),
        .in_ready  (dv_ready[DIV_STAGES]),
        .in_word   (dv_word[DIV_STAGES]),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .saturated (saturated),
        .out_last  (out_last)
    );

endmodule

// File: rtl/vtp_checker.sv
// Port-level checker for the vertex transform block, bound to the top level.
`include "vertex_transform_project_macros.svh"

module vtp_checker #(
    parameter int DIV_BITS = vtp_pkg::DIV_BITS_DEFAULT
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [vtp_pkg::COORD_W-1:0] out_x,
    input logic signed [vtp_pkg::COORD_W-1:0] out_y,
    input logic signed [vtp_pkg::COORD_W-1:0] out_z,
    input logic                               saturated,
    input logic                               out_last
);

    localparam int DEPTH = 3 + vtp_pkg::QUOT_W / DIV_BITS;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic             in_acc;
    logic             out_acc;
    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    // Count of words accepted but not yet delivered.
    assign in_acc        = in_valid && !in_stall;
    assign out_acc       = out_valid && !out_stall;
    assign inflight_next = inflight_reg + CNT_W'(in_acc) - CNT_W'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result word stays and does not change.
    `VTP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z)
        && $stable(saturated) && $stable(out_last))

    // Without back-pressure at the output the input never stalls.
    `VTP_ASSERT_NOW(a_no_idle_stall, clk, rst_n, !out_stall, !in_stall)

    // No result word appears without an accepted vertex behind it.
    `VTP_ASSERT_NOW(a_no_phantom, clk, rst_n, out_valid, inflight_reg != '0)

    // The pipeline never holds more words than it has stages.
    `VTP_ASSERT_NOW(a_depth, clk, rst_n, 1'b1, inflight_reg <= CNT_W'(DEPTH))

endmodule

bind vertex_transform_project vtp_checker #(
    .DIV_BITS (DIV_BITS)
) u_vtp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .saturated (saturated),
    .out_last  (out_last)
);
